@@ sv/hphw_pkg.sv @@
package hphw_pkg;

  localparam int unsigned PAGE_SIZE   = 131072;
  localparam int unsigned GRANULE     = 8;
  localparam int unsigned INDEX_COUNT = 16384;
  localparam int unsigned HDR_BYTES   = 8;
  localparam int unsigned Q_DEPTH     = 4;

  localparam int unsigned IDX_W  = 14;
  localparam int unsigned PHS_W  = 17;
  localparam int unsigned ADDR_W = 64;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned BYTE_W = 48;
  localparam int unsigned CUR_W  =
      ($clog2(PAGE_SIZE + 1) > 18) ? $clog2(PAGE_SIZE + 1) : 18;
  localparam int unsigned SIZE_W = 15 + $clog2(GRANULE);
  localparam int unsigned SUM_W  = ((CUR_W > SIZE_W) ? CUR_W : SIZE_W) + 1;

  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [BYTE_W-1:0] BYTE_MAX = '1;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_HEADER = 2'd1,
    CMD_FAIL   = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  // one classified beat handed from the front to the back
  typedef struct packed {
    logic              free_add;
    logic              live_add;
    logic              tail_add;
    logic              query_hit;
    logic [IDX_W-1:0]  idx;
    logic [SIZE_W-1:0] size;
    logic [CUR_W-1:0]  cursor;
    logic [ADDR_W-1:0] base;
    logic              walking;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [BYTE_W-1:0] bytes;
  } entry_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a);
    sat_inc = (a == CNT_MAX) ? a : a + 1'b1;
  endfunction

  function automatic logic [BYTE_W-1:0] sat_add(input logic [BYTE_W-1:0] a,
                                                input logic [BYTE_W-1:0] b);
    logic [BYTE_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    sat_add = (sum >= {1'b0, BYTE_MAX}) ? BYTE_MAX : sum[BYTE_W-1:0];
  endfunction

endpackage

@@ sv/hphw_fifo.sv @@
module hphw_fifo #(
  parameter int unsigned DEPTH = hphw_pkg::Q_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  hphw_pkg::op_t         data_i,
  input  logic                  pop_i,
  output hphw_pkg::op_t         data_o,
  output hphw_pkg::q_status_t   status_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW = $clog2(DEPTH + 1);

  hphw_pkg::op_t   mem_q [DEPTH];
  logic [PW-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [LW-1:0]   lvl_q, lvl_d;
  logic            do_push, do_pop;

  assign do_push = push_i && (lvl_q != LW'(DEPTH));
  assign do_pop  = pop_i && (lvl_q != '0);

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    lvl_d = lvl_q;
    if (do_push) begin
      wp_d = (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (do_pop) begin
      rp_d = (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      lvl_d = lvl_q + 1'b1;
    end else if (do_pop && !do_push) begin
      lvl_d = lvl_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      lvl_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      lvl_q <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

  assign data_o         = mem_q[rp_q];
  assign status_o.full  = (lvl_q == LW'(DEPTH));
  assign status_o.empty = (lvl_q == '0);

endmodule

@@ sv/hphw_front.sv @@
module hphw_front #(
  parameter int unsigned INDEX_COUNT = hphw_pkg::INDEX_COUNT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    command_i,
  input  logic [63:0]                   page_addr_i,
  input  logic [15:0]                   header_high_i,
  input  logic [15:0]                   header_low_i,
  input  logic [13:0]                   query_index_i,
  input  logic [hphw_pkg::PHS_W-1:0]    page_header_size_i,
  input  logic                          clr_busy_i,
  input  hphw_pkg::q_status_t           q_status_i,
  output logic                          push_o,
  output hphw_pkg::op_t                 op_o
);

  localparam int unsigned AW   = $clog2(INDEX_COUNT);
  localparam int unsigned CMPW =
      (AW + 1 > hphw_pkg::IDX_W + 1) ? AW + 1 : hphw_pkg::IDX_W + 1;
  localparam int unsigned CW   = hphw_pkg::CUR_W;
  localparam int unsigned SW   = hphw_pkg::SUM_W;
  localparam logic [SW-1:0] PAGE_END  = SW'(hphw_pkg::PAGE_SIZE);
  localparam logic [SW-1:0] LAST_HDR  =
      SW'(hphw_pkg::PAGE_SIZE - hphw_pkg::HDR_BYTES);
  localparam logic [CW-1:0] GRAN_LOW  = CW'(hphw_pkg::GRANULE - 1);

  logic [63:0]                   base_q, base_d;
  logic [CW-1:0]                 cursor_q, cursor_d;
  logic                          walking_q, walking_d;
  logic                          accept;
  logic [hphw_pkg::SIZE_W-1:0]   size;
  logic [hphw_pkg::IDX_W-1:0]    hdr_idx;
  logic                          hdr_in_range, qry_in_range;
  logic [CW-1:0]                 start_cur;
  logic [SW-1:0]                 hdr_sum;
  logic                          hdr_bad;
  hphw_pkg::op_t                 op;

  assign in_stall_o = clr_busy_i || q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  assign size    = hphw_pkg::SIZE_W'(header_low_i[15:1]) *
                   hphw_pkg::SIZE_W'(hphw_pkg::GRANULE);
  assign hdr_idx = header_high_i[hphw_pkg::IDX_W-1:0];

  assign hdr_in_range = CMPW'(hdr_idx) < CMPW'(INDEX_COUNT);
  assign qry_in_range = CMPW'(query_index_i) < CMPW'(INDEX_COUNT);

  assign start_cur = (CW'(page_header_size_i) + GRAN_LOW) & ~GRAN_LOW;
  assign hdr_sum   = SW'(cursor_q) + SW'(size);
  assign hdr_bad   = (size == '0) || !hdr_in_range || (hdr_sum > PAGE_END);

  always_comb begin
    base_d       = base_q;
    cursor_d     = cursor_q;
    walking_d    = walking_q;
    op           = '0;
    op.idx       = hdr_idx;
    op.size      = size;
    case (command_i)
      hphw_pkg::CMD_START: begin
        base_d    = page_addr_i;
        cursor_d  = start_cur;
        walking_d = 1'b1;
        if (SW'(start_cur) > LAST_HDR) begin
          walking_d   = 1'b0;
          op.tail_add = 1'b1;
        end
      end
      hphw_pkg::CMD_HEADER: begin
        if (walking_q) begin
          if (hdr_bad) begin
            walking_d   = 1'b0;
            op.tail_add = 1'b1;
          end else begin
            op.free_add = (hdr_idx == '0);
            op.live_add = (hdr_idx != '0);
            cursor_d    = CW'(hdr_sum);
            if (hdr_sum > LAST_HDR) begin
              walking_d   = 1'b0;
              op.tail_add = 1'b1;
            end
          end
        end
      end
      hphw_pkg::CMD_FAIL: begin
        if (walking_q) begin
          walking_d   = 1'b0;
          op.tail_add = 1'b1;
        end
      end
      hphw_pkg::CMD_QUERY: begin
        op.idx       = query_index_i;
        op.query_hit = qry_in_range;
      end
      default: begin
      end
    endcase
    op.base    = base_d;
    op.cursor  = cursor_d;
    op.walking = walking_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      cursor_q  <= '0;
      walking_q <= 1'b0;
    end else if (accept) begin
      base_q    <= base_d;
      cursor_q  <= cursor_d;
      walking_q <= walking_d;
    end
  end

  assign push_o = accept;
  assign op_o   = op;

endmodule

@@ sv/hphw_back.sv @@
module hphw_back #(
  parameter int unsigned INDEX_COUNT = hphw_pkg::INDEX_COUNT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hphw_pkg::op_t                 head_i,
  input  hphw_pkg::q_status_t           q_status_i,
  output logic                          pop_o,
  output logic                          clr_busy_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [63:0]                   read_address_o,
  output logic                          page_active_o,
  output logic [31:0]                   free_tally_o,
  output logic [47:0]                   free_size_o,
  output logic [31:0]                   live_tally_o,
  output logic [47:0]                   live_size_o,
  output logic [47:0]                   tail_bytes_o,
  output logic [31:0]                   entry_count_o,
  output logic [47:0]                   entry_bytes_o
);

  localparam int unsigned AW = (INDEX_COUNT > 1) ? $clog2(INDEX_COUNT) : 1;
  localparam int unsigned CW = hphw_pkg::CUR_W;
  localparam int unsigned BW = hphw_pkg::BYTE_W;
  localparam logic [CW-1:0] PAGE_END = CW'(hphw_pkg::PAGE_SIZE);

  hphw_pkg::entry_t  mem [INDEX_COUNT];

  logic [AW-1:0]     clr_cnt_q;
  logic              clr_busy_q;

  logic              s1_valid_q;
  hphw_pkg::op_t     s1_op_q;
  logic [CW-1:0]     s1_tail_q;
  hphw_pkg::entry_t  rd_q;
  logic              fwd_q;
  hphw_pkg::entry_t  fwd_data_q;

  logic              out_valid_q;
  logic [63:0]       addr_q;
  logic              active_q;
  logic [31:0]       ent_cnt_q;
  logic [47:0]       ent_bytes_q;

  logic [31:0]       free_cnt_q, live_cnt_q;
  logic [BW-1:0]     free_size_q, live_size_q, tail_q;

  logic              out_ready, s1_adv, s1_load;
  logic [AW-1:0]     head_addr, s1_addr;
  logic [CW-1:0]     head_tail;
  hphw_pkg::entry_t  cur_entry, new_entry;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  hphw_pkg::entry_t  wr_data;
  logic [BW-1:0]     s1_size;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign s1_adv    = s1_valid_q && out_ready;
  assign s1_load   = !q_status_i.empty && (!s1_valid_q || s1_adv);
  assign pop_o     = s1_load;

  assign head_addr = AW'(head_i.idx);
  assign s1_addr   = AW'(s1_op_q.idx);
  assign head_tail = (head_i.tail_add && (head_i.cursor < PAGE_END)) ?
                     PAGE_END - head_i.cursor : '0;

  // the beat ahead may have written this index at the edge of our read
  assign cur_entry     = fwd_q ? fwd_data_q : rd_q;
  assign s1_size       = BW'(s1_op_q.size);
  assign new_entry.cnt   = hphw_pkg::sat_inc(cur_entry.cnt);
  assign new_entry.bytes = hphw_pkg::sat_add(cur_entry.bytes, s1_size);

  always_comb begin
    if (clr_busy_q) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_q;
      wr_data = '0;
    end else begin
      wr_en   = s1_adv && s1_op_q.live_add;
      wr_addr = s1_addr;
      wr_data = new_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (s1_load) begin
      rd_q <= mem[head_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == AW'(INDEX_COUNT - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_op_q    <= head_i;
      s1_tail_q  <= head_tail;
      fwd_q      <= s1_adv && s1_op_q.live_add && (s1_addr == head_addr);
      fwd_data_q <= new_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      free_cnt_q  <= '0;
      free_size_q <= '0;
      live_cnt_q  <= '0;
      live_size_q <= '0;
      tail_q      <= '0;
    end else begin
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        if (s1_op_q.free_add) begin
          free_cnt_q  <= hphw_pkg::sat_inc(free_cnt_q);
          free_size_q <= hphw_pkg::sat_add(free_size_q, s1_size);
        end
        if (s1_op_q.live_add) begin
          live_cnt_q  <= hphw_pkg::sat_inc(live_cnt_q);
          live_size_q <= hphw_pkg::sat_add(live_size_q, s1_size);
        end
        if (s1_op_q.tail_add) begin
          tail_q <= hphw_pkg::sat_add(tail_q, BW'(s1_tail_q));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      addr_q      <= s1_op_q.base + 64'(s1_op_q.cursor);
      active_q    <= s1_op_q.walking;
      ent_cnt_q   <= s1_op_q.query_hit ? cur_entry.cnt : '0;
      ent_bytes_q <= s1_op_q.query_hit ? cur_entry.bytes : '0;
    end
  end

  assign clr_busy_o     = clr_busy_q;
  assign out_valid_o    = out_valid_q;
  assign read_address_o = addr_q;
  assign page_active_o  = active_q;
  assign free_tally_o   = free_cnt_q;
  assign free_size_o    = free_size_q;
  assign live_tally_o   = live_cnt_q;
  assign live_size_o    = live_size_q;
  assign tail_bytes_o   = tail_q;
  assign entry_count_o  = ent_cnt_q;
  assign entry_bytes_o  = ent_bytes_q;

endmodule

@@ sv/heap_page_header_walker.sv @@
// channel  role       handshake                    payload
// in       sink       in_valid_i / in_stall_o      command, page_addr, header_high/low, query_index
// out      source     out_valid_o / out_stall_i    read_address, page_active, totals, entry fields
// cfg      APB slave  psel/penable/pwrite/pready   page_header_size at byte address 0
//
// One beat per cycle sustained while out_stall_i is low and no table clear runs; a result passes
// the queue entry, table read stage and output register after its input beat is taken.
// The per-index table has one read and one write port; the write of one beat is forwarded
// to the read of the following beat.
// After reset the table is cleared one entry a cycle: in_stall_o is high until all INDEX_COUNT
// entries are cleared, config writes are taken meanwhile. A four-deep queue lets either side stall.
module heap_page_header_walker #(
  parameter int unsigned INDEX_COUNT = hphw_pkg::INDEX_COUNT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [63:0] page_addr_i,
  input  logic [15:0] header_high_i,
  input  logic [15:0] header_low_i,
  input  logic [13:0] query_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] read_address_o,
  output logic        page_active_o,
  output logic [31:0] free_tally_o,
  output logic [47:0] free_size_o,
  output logic [31:0] live_tally_o,
  output logic [47:0] live_size_o,
  output logic [47:0] tail_bytes_o,
  output logic [31:0] entry_count_o,
  output logic [47:0] entry_bytes_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_PHS = 1'b0;

  logic [hphw_pkg::PHS_W-1:0] phs_q;
  logic                       cfg_wr;
  logic                       push, pop, clr_busy;
  hphw_pkg::op_t              op_in, op_head;
  hphw_pkg::q_status_t        q_status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_PHS) ? 32'(phs_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phs_q <= '0;
    end else if (cfg_wr && (paddr[2] == REG_PHS)) begin
      phs_q <= pwdata[hphw_pkg::PHS_W-1:0];
    end
  end

  hphw_front #(
    .INDEX_COUNT (INDEX_COUNT)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .page_addr_i        (page_addr_i),
    .header_high_i      (header_high_i),
    .header_low_i       (header_low_i),
    .query_index_i      (query_index_i),
    .page_header_size_i (phs_q),
    .clr_busy_i         (clr_busy),
    .q_status_i         (q_status),
    .push_o             (push),
    .op_o               (op_in)
  );

  hphw_fifo #(
    .DEPTH (hphw_pkg::Q_DEPTH)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (op_in),
    .pop_i    (pop),
    .data_o   (op_head),
    .status_o (q_status)
  );

  hphw_back #(
    .INDEX_COUNT (INDEX_COUNT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (op_head),
    .q_status_i     (q_status),
    .pop_o          (pop),
    .clr_busy_o     (clr_busy),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .read_address_o (read_address_o),
    .page_active_o  (page_active_o),
    .free_tally_o   (free_tally_o),
    .free_size_o    (free_size_o),
    .live_tally_o   (live_tally_o),
    .live_size_o    (live_size_o),
    .tail_bytes_o   (tail_bytes_o),
    .entry_count_o  (entry_count_o),
    .entry_bytes_o  (entry_bytes_o)
  );

`ifndef SYNTHESIS
  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> in_stall_o)
    else $error("beat could be taken while the table is being cleared");

  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !out_valid_o)
    else $error("result shown while the table is being cleared");

  a_queue_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty together");

  a_pop_needs_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("back pops an empty queue");
`endif

endmodule
